// File: hdl/contiguous_segment_allocator_top_defines.svh
// Assertion macros shared by the checker.
`ifndef CONTIGUOUS_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH
`define CONTIGUOUS_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH

`define CSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define CSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/csa_pkg.sv
package csa_pkg;
    localparam int MAX_SEGS_DEF  = 32;
    localparam int ADDR_BITS_DEF = 20;
    localparam int OWNER_W       = 16;
    localparam int REQ_W         = 21;
    localparam int CFG_W         = 21;

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_RELEASE = 2'd1,
        OP_COMPACT = 2'd2,
        OP_STATUS  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_BAD   = 2'd3
    } t_fit;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_FIT   = 3'd1,
        ST_NO_OWNER = 3'd2,
        ST_FULL     = 3'd3,
        ST_BAD_MODE = 3'd4
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic init;     // reload table from total size
        logic latch;    // capture request
        logic scan_clr; // restart scan
        logic scan_step;// examine entry at scan index
        logic apply;    // perform chosen edit (one step)
        logic emit;     // load output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic edit_done;
        logic list_last;
    } t_sts;
endpackage

// File: hdl/csa_if.sv
interface csa_in_if;
    import csa_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          op;
    logic [OWNER_W-1:0]  owner_id;
    logic [REQ_W-1:0]    units;
    logic [1:0]          fit_choice;
    modport source (output valid, op, owner_id, units, fit_choice, input ready);
    modport sink (input valid, op, owner_id, units, fit_choice, output ready);
endinterface

interface csa_out_if #(parameter int ADDR_BITS = csa_pkg::ADDR_BITS_DEF);
    logic                 valid;
    logic                 ready;
    logic [2:0]           status;
    logic [ADDR_BITS-1:0] alloc_base;
    logic [ADDR_BITS-1:0] seg_base;
    logic [ADDR_BITS:0]   seg_size;
    logic [15:0]          seg_owner;
    logic                 seg_unused;
    logic                 last;
    modport source (output valid, status, alloc_base, seg_base, seg_size, seg_owner,
                    seg_unused, last, input ready);
    modport sink (input valid, status, alloc_base, seg_base, seg_size, seg_owner,
                  seg_unused, last, output ready);
endinterface

// File: hdl/csa_datapath.sv
module csa_datapath #(
    parameter int MAX_SEGS  = csa_pkg::MAX_SEGS_DEF,
    parameter int ADDR_BITS = csa_pkg::ADDR_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [csa_pkg::CFG_W-1:0]   i_cfg_data,
    input  csa_pkg::t_cmd               i_cmd,
    output csa_pkg::t_sts               o_sts,
    output logic [2:0]                  o_verdict,
    input  logic [1:0]                  i_op,
    input  logic [15:0]                 i_owner,
    input  logic [csa_pkg::REQ_W-1:0]   i_size,
    input  logic [1:0]                  i_fit,
    output logic [2:0]                  o_status,
    output logic [ADDR_BITS-1:0]        o_alloc_base,
    output logic [ADDR_BITS-1:0]        o_seg_base,
    output logic [ADDR_BITS:0]          o_seg_size,
    output logic [15:0]                 o_seg_owner,
    output logic                        o_seg_unused,
    output logic                        o_last
);
    import csa_pkg::*;

    localparam int IW = $clog2(MAX_SEGS);
    localparam int CW = $clog2(MAX_SEGS + 1);
    localparam int LW = ADDR_BITS + 1;
    localparam int XW = CFG_W + LW;

    // table held as a shift-capable register row; every entry shifts in place
    logic [ADDR_BITS-1:0] r_base  [MAX_SEGS];
    logic [LW-1:0]        r_len   [MAX_SEGS];
    logic [15:0]          r_own   [MAX_SEGS];
    logic [MAX_SEGS-1:0]  r_free;
    logic [CW-1:0]        r_cnt;

    logic [1:0]           r_op;
    logic [15:0]          r_owner;
    logic [REQ_W-1:0]     r_size;
    logic [1:0]           r_fit;
    logic [CW-1:0]        r_k;
    logic [IW-1:0]        r_t;
    logic                 r_found;
    logic [LW-1:0]        r_addr;
    logic [LW-1:0]        r_spare;
    logic [CW-1:0]        r_w;
    logic [1:0]           r_phase;

    logic [IW-1:0]        k_idx;
    logic                 k_in;
    logic [LW-1:0]        size_w;
    logic [XW-1:0]        cfg_ext;
    logic [LW-1:0]        cfg_clip;

    assign k_idx  = r_k[IW-1:0];
    assign k_in   = (r_k < r_cnt);
    assign size_w = LW'(r_size);
    assign cfg_ext = XW'(i_cfg_data);

    always_comb begin
        if (i_cfg_data == '0) cfg_clip = LW'(1);
        else if (cfg_ext > (XW'(1) << ADDR_BITS))
            cfg_clip = LW'(1) << ADDR_BITS;
        else cfg_clip = cfg_ext[LW-1:0];
    end

    logic size_big;
    assign size_big = (REQ_W > LW) ? ((r_size >> LW) != '0) : 1'b0;

    logic cand;
    assign cand = k_in && r_free[k_idx] && !size_big && (r_len[k_idx] >= size_w);

    // edit result of one step
    logic exact;
    assign exact = (r_len[r_t] == size_w);

    logic [2:0] n_status;
    logic [ADDR_BITS-1:0] n_alloc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= CW'(1);
            r_free  <= MAX_SEGS'(1);
            r_base[0] <= '0;
            r_len[0]  <= LW'(1) << ADDR_BITS;
            r_own[0]  <= '0;
            r_k <= '0; r_found <= 1'b0; r_phase <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cnt     <= CW'(1);
                r_free    <= MAX_SEGS'(1);
                r_base[0] <= '0;
                r_len[0]  <= cfg_clip;
                r_own[0]  <= '0;
            end
            if (i_cmd.latch) begin
                r_op <= i_op; r_owner <= i_owner; r_size <= i_size; r_fit <= i_fit;
            end
            if (i_cmd.scan_clr) begin
                r_k <= '0; r_found <= 1'b0; r_phase <= '0;
                r_addr <= '0; r_spare <= '0; r_w <= '0;
            end
            if (i_cmd.scan_step) begin
                r_k <= r_k + CW'(1);
                unique case (t_op'(r_op))
                    OP_REQUEST: begin
                        if (cand && !r_found) begin
                            r_t <= k_idx; r_found <= 1'b1;
                        end else if (cand && r_fit == FIT_BEST && r_len[k_idx] < r_len[r_t]) begin
                            r_t <= k_idx;
                        end else if (cand && r_fit == FIT_WORST && r_len[k_idx] > r_len[r_t]) begin
                            r_t <= k_idx;
                        end
                    end
                    OP_RELEASE: begin
                        if (k_in && !r_found && !r_free[k_idx] && r_own[k_idx] == r_owner) begin
                            r_t <= k_idx; r_found <= 1'b1;
                        end
                    end
                    OP_COMPACT: begin
                        // pack owned entries down one per step
                        if (k_in) begin
                            if (r_free[k_idx]) begin
                                r_spare <= r_spare + r_len[k_idx];
                            end else begin
                                r_base[r_w[IW-1:0]] <= r_addr[ADDR_BITS-1:0];
                                r_len[r_w[IW-1:0]]  <= r_len[k_idx];
                                r_own[r_w[IW-1:0]]  <= r_own[k_idx];
                                r_free[r_w[IW-1:0]] <= 1'b0;
                                r_addr <= r_addr + r_len[k_idx];
                                r_w    <= r_w + CW'(1);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.apply) begin
                unique case (t_op'(r_op))
                    OP_REQUEST: begin
                        if (!exact) begin
                            for (int j = MAX_SEGS - 1; j >= 1; j--) begin
                                if (IW'(j) > r_t + IW'(1)) begin
                                    r_base[j] <= r_base[j-1]; r_len[j] <= r_len[j-1];
                                    r_own[j]  <= r_own[j-1];  r_free[j] <= r_free[j-1];
                                end
                            end
                            r_base[r_t + IW'(1)] <= r_base[r_t] + size_w[ADDR_BITS-1:0];
                            r_len[r_t + IW'(1)]  <= r_len[r_t] - size_w;
                            r_own[r_t + IW'(1)]  <= '0;
                            r_free[r_t + IW'(1)] <= 1'b1;
                            r_len[r_t] <= size_w;
                            r_cnt <= r_cnt + CW'(1);
                        end
                        r_own[r_t]  <= r_owner;
                        r_free[r_t] <= 1'b0;
                    end
                    OP_RELEASE: begin
                        // phase 0: free and merge upward; phase 1: merge downward
                        if (r_phase == 2'd0) begin
                            r_free[r_t] <= 1'b1;
                            r_own[r_t]  <= '0;
                            r_phase <= 2'd1;
                            if ((CW'(r_t) + CW'(1) < r_cnt) && r_free[r_t + IW'(1)]) begin
                                r_len[r_t] <= r_len[r_t] + r_len[r_t + IW'(1)];
                                for (int j = 0; j < MAX_SEGS - 1; j++) begin
                                    if (IW'(j) > r_t) begin
                                        r_base[j] <= r_base[j+1]; r_len[j] <= r_len[j+1];
                                        r_own[j]  <= r_own[j+1];  r_free[j] <= r_free[j+1];
                                    end
                                end
                                r_free[MAX_SEGS-1] <= 1'b0;
                                r_cnt <= r_cnt - CW'(1);
                            end
                        end else begin
                            r_phase <= 2'd2;
                            if (r_t != '0 && r_free[r_t - IW'(1)]) begin
                                r_len[r_t - IW'(1)] <= r_len[r_t - IW'(1)] + r_len[r_t];
                                for (int j = 0; j < MAX_SEGS - 1; j++) begin
                                    if (IW'(j) >= r_t) begin
                                        r_base[j] <= r_base[j+1]; r_len[j] <= r_len[j+1];
                                        r_own[j]  <= r_own[j+1];  r_free[j] <= r_free[j+1];
                                    end
                                end
                                r_free[MAX_SEGS-1] <= 1'b0;
                                r_cnt <= r_cnt - CW'(1);
                            end
                        end
                    end
                    OP_COMPACT: begin
                        r_phase <= 2'd2;
                        if (r_spare != '0 && r_w < CW'(MAX_SEGS)) begin
                            r_base[r_w[IW-1:0]] <= r_addr[ADDR_BITS-1:0];
                            r_len[r_w[IW-1:0]]  <= r_spare;
                            r_own[r_w[IW-1:0]]  <= '0;
                            r_free[r_w[IW-1:0]] <= 1'b1;
                            r_cnt <= r_w + CW'(1);
                        end else begin
                            r_cnt <= r_w;
                        end
                        for (int j = 0; j < MAX_SEGS; j++) begin
                            if (CW'(j) > r_w) r_free[j] <= 1'b0;
                        end
                        if (r_spare == '0) r_free[r_w[IW-1:0]] <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // request and release decision once the scan has ended
    always_comb begin
        n_status = ST_OK;
        n_alloc  = '0;
        unique case (t_op'(r_op))
            OP_REQUEST: begin
                if (r_fit == FIT_BAD) n_status = ST_BAD_MODE;
                else if (r_size == '0 || !r_found) n_status = ST_NO_FIT;
                else if (!exact && r_cnt >= CW'(MAX_SEGS)) n_status = ST_FULL;
                else n_alloc = r_base[r_t];
            end
            OP_RELEASE: n_status = r_found ? ST_OK : ST_NO_OWNER;
            default: n_status = ST_OK;
        endcase
    end

    assign o_verdict = n_status;

    always_comb begin
        o_sts.scan_done = (r_k >= r_cnt) || (r_op == OP_RELEASE && r_found);
        o_sts.edit_done = (r_op != OP_RELEASE) || (r_phase != 2'd0);
        o_sts.list_last = (r_k + CW'(1) >= r_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_op == OP_STATUS) begin
                o_status     <= ST_OK;
                o_alloc_base <= '0;
                o_seg_base   <= r_base[k_idx];
                o_seg_size   <= r_len[k_idx];
                o_seg_owner  <= r_free[k_idx] ? 16'd0 : r_own[k_idx];
                o_seg_unused <= r_free[k_idx];
                o_last       <= (r_k + CW'(1) >= r_cnt);
            end else begin
                o_status     <= n_status;
                o_alloc_base <= n_alloc;
                o_seg_base   <= '0;
                o_seg_size   <= '0;
                o_seg_owner  <= '0;
                o_seg_unused <= 1'b0;
                o_last       <= 1'b1;
            end
        end
    end
endmodule

// File: hdl/csa_ctrl.sv
module csa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_op,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  logic [2:0]    i_status,
    output csa_pkg::t_cmd o_cmd,
    input  csa_pkg::t_sts i_sts
);
    import csa_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_APPLY = 6'b000100,
        S_EMIT  = 6'b001000,
        S_WAIT  = 6'b010000,
        S_LIST  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_oval, n_oval;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_oval;

    always_comb begin
        n_state = r_state;
        n_oval  = r_oval && !i_out_ready;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state = (i_op == OP_STATUS) ? S_LIST : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_APPLY;
                else o_cmd.scan_step = 1'b1;
            end
            S_APPLY: begin
                if (i_status == ST_OK) o_cmd.apply = 1'b1;
                if (i_sts.edit_done || i_status != ST_OK) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_oval) begin
                    o_cmd.emit = 1'b1;
                    n_oval = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: n_state = S_IDLE;
            S_LIST: begin
                if (!r_oval || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.scan_step = 1'b1;
                    n_oval = 1'b1;
                    if (i_sts.list_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
        end
    end
endmodule

// File: hdl/contiguous_segment_allocator_top.sv
// Contiguous segment allocator with first, best and worst fit over a table of up to
// MAX_SEGS segments. One request is taken at a time: i_req.ready is high only while the
// block is idle. A request, release or compact scans the table one entry per cycle
// (a release stops once the owner's entry is found), edits it (a release merges upward,
// then downward), loads its single result once no earlier result is pending, and is ready
// again after a wait state. A status listing gives one result per segment, one per cycle
// while o_res.ready stays high, and is ready again the cycle after the last one is loaded.
// A result that is not taken holds back the next one.
// Writing total_size (0 becomes 1, above 2^ADDR_BITS is clipped) resets the table to one
// free segment; write it only while idle with no result pending.
module contiguous_segment_allocator_top #(
    parameter int MAX_SEGS  = csa_pkg::MAX_SEGS_DEF,
    parameter int ADDR_BITS = csa_pkg::ADDR_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [csa_pkg::CFG_W-1:0] i_cfg_data,
    csa_in_if.sink                    i_req,
    csa_out_if.source                 o_res
);
    import csa_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic out_valid;
    logic [2:0] dp_status;

    csa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready), .i_op(i_req.op),
        .i_out_ready(o_res.ready), .o_out_valid(out_valid),
        .i_status(dp_status), .o_cmd(cmd), .i_sts(sts)
    );

    csa_datapath #(.MAX_SEGS(MAX_SEGS), .ADDR_BITS(ADDR_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_cmd(cmd), .o_sts(sts), .o_verdict(dp_status),
        .i_op(i_req.op), .i_owner(i_req.owner_id), .i_size(i_req.units),
        .i_fit(i_req.fit_choice),
        .o_status(o_res.status), .o_alloc_base(o_res.alloc_base),
        .o_seg_base(o_res.seg_base), .o_seg_size(o_res.seg_size),
        .o_seg_owner(o_res.seg_owner), .o_seg_unused(o_res.seg_unused),
        .o_last(o_res.last)
    );

    assign o_res.valid = out_valid;
endmodule

// File: hdl/csa_checker.sv
`include "contiguous_segment_allocator_top_defines.svh"
module csa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic       last
);
    `CSA_ASSERT_IMPL(a_status_range, i_clk, i_rst_n, out_valid, status <= 3'd4)
    `CSA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
    `CSA_ASSERT_IMPL(a_one_at_a_time, i_clk, i_rst_n, in_ready, !(out_valid && !last && in_ready))
    `CSA_ASSERT_NEXT(a_req_hold, i_clk, i_rst_n, in_valid && !in_ready, in_valid)
endmodule

bind contiguous_segment_allocator_top csa_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_req.valid), .in_ready(i_req.ready),
    .out_valid(o_res.valid), .out_ready(o_res.ready),
    .status(o_res.status), .last(o_res.last)
);
